### design/pidc_pkg.sv
package pidc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_INDEX_W = 3;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_SETPOINT       = 3'd0;
  localparam cfg_index_t REG_KP             = 3'd1;
  localparam cfg_index_t REG_KI             = 3'd2;
  localparam cfg_index_t REG_KD             = 3'd3;
  localparam cfg_index_t REG_INTEGRAL_LIMIT = 3'd4;
  localparam cfg_index_t REG_LOOP_MODE      = 3'd5;

  typedef logic [1:0] loop_mode_t;

  localparam loop_mode_t MODE_PID    = 2'd0;
  localparam loop_mode_t MODE_PI     = 2'd1;
  localparam loop_mode_t MODE_PI_AW  = 2'd2;

  // Per-item flags that follow the data down the pipeline.
  typedef struct packed {
    logic clip;
    logic use_d;
  } stage_ctl_t;

endpackage

### design/pidc_loop.sv
module pidc_loop #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic signed [DATA_WIDTH-1:0] measured,
  input  logic signed [DATA_WIDTH-1:0] setpoint,
  input  logic        [DATA_WIDTH-2:0] integral_limit,
  input  pidc_pkg::loop_mode_t         loop_mode,
  output logic signed [DATA_WIDTH-1:0] err,
  output logic signed [DATA_WIDTH-1:0] acc,
  output logic signed [DATA_WIDTH:0]   diff,
  output pidc_pkg::stage_ctl_t         ctl
);
  import pidc_pkg::*;

  // 0.2 rounded to the nearest step of the fixed-point format.
  localparam logic signed [DATA_WIDTH-1:0] THRESH =
    (DATA_WIDTH)'(((2 ** FRAC_BITS) * 2 + 5) / 10);
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] previous_error;
  logic signed [DATA_WIDTH-1:0] integral_sum;

  logic signed [DATA_WIDTH:0]   delta;
  logic signed [DATA_WIDTH:0]   sum_raw;
  logic signed [DATA_WIDTH:0]   lim_pos;
  logic signed [DATA_WIDTH:0]   lim_neg;
  logic signed [DATA_WIDTH-1:0] inc;
  logic                         ovf;

  always_comb begin
    delta = {setpoint[DATA_WIDTH-1], setpoint} - {measured[DATA_WIDTH-1], measured};
    ovf   = delta[DATA_WIDTH] ^ delta[DATA_WIDTH-1];
    if (ovf) begin
      err = delta[DATA_WIDTH] ? MINV : MAXV;
    end else begin
      err = delta[DATA_WIDTH-1:0];
    end

    // Anti-windup mode integrates only half of a large positive error.
    if (loop_mode == MODE_PI_AW && err >= THRESH) begin
      inc = err >>> 1;
    end else begin
      inc = err;
    end

    sum_raw = {integral_sum[DATA_WIDTH-1], integral_sum} + {inc[DATA_WIDTH-1], inc};
    lim_pos = {2'b00, integral_limit};
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      acc = lim_pos[DATA_WIDTH-1:0];
    end else if (sum_raw < lim_neg) begin
      acc = lim_neg[DATA_WIDTH-1:0];
    end else begin
      acc = sum_raw[DATA_WIDTH-1:0];
    end

    diff      = {err[DATA_WIDTH-1], err} - {previous_error[DATA_WIDTH-1], previous_error};
    ctl.clip  = ovf;
    ctl.use_d = (loop_mode == MODE_PID);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (step) begin
      previous_error <= err;
      integral_sum   <= acc;
    end
  end

endmodule

### design/pid_controller_clamped_integral.sv
// Each accepted input item moves through stages a, b and c into the output
// register, and waits in any of them while the output side stalls.
// Throughput: one item per cycle unless the output stalls; the error and integral
// loop updates as an item enters stage b; the three gain products sit in stage c.
// Reset (rst, synchronous, active high) clears the configuration registers, the
// previous error, the integral and every pipeline valid bit, but not the data.
module pid_controller_clamped_integral #(
  parameter  int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter  int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF,
  localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // measured
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // drive
  output logic                  m_tuser,   // clipped
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  pidc_pkg::cfg_index_t  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);
  import pidc_pkg::*;

  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Configuration registers
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] kp;
  logic signed [DATA_WIDTH-1:0] ki;
  logic signed [DATA_WIDTH-1:0] kd;
  logic        [DATA_WIDTH-2:0] integral_limit;
  loop_mode_t                   loop_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      kp             <= '0;
      ki             <= '0;
      kd             <= '0;
      integral_limit <= '0;
      loop_mode      <= MODE_PID;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT:       setpoint       <= cfg_data;
        REG_KP:             kp             <= cfg_data;
        REG_KI:             ki             <= cfg_data;
        REG_KD:             kd             <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[DATA_WIDTH-2:0];
        REG_LOOP_MODE:      loop_mode      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline registers
  logic                         a_valid;
  logic signed [DATA_WIDTH-1:0] a_meas;
  logic                         b_valid;
  logic signed [DATA_WIDTH-1:0] b_err;
  logic signed [DATA_WIDTH-1:0] b_acc;
  logic signed [DATA_WIDTH:0]   b_diff;
  stage_ctl_t                   b_ctl;
  logic                         c_valid;
  logic signed [PW-1:0]         c_p;
  logic signed [PW-1:0]         c_i;
  logic signed [PW:0]           c_d;
  logic                         c_clip;
  logic [DATA_WIDTH-1:0]        drive;
  logic                         clipped;

  // A stage loads when it is empty or its contents move on, so bubbles collapse.
  logic en_out, en_c, en_b, en_a;
  assign en_out   = !m_tvalid || m_tready;
  assign en_c     = !c_valid || en_out;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign s_tready = en_a;

  logic signed [DATA_WIDTH-1:0] lp_err;
  logic signed [DATA_WIDTH-1:0] lp_acc;
  logic signed [DATA_WIDTH:0]   lp_diff;
  stage_ctl_t                   lp_ctl;

  // The loop state advances exactly once per item, as it moves into stage b.
  pidc_loop #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_loop (
    .clk           (clk),
    .rst           (rst),
    .step          (en_b && a_valid),
    .measured      (a_meas),
    .setpoint      (setpoint),
    .integral_limit(integral_limit),
    .loop_mode     (loop_mode),
    .err           (lp_err),
    .acc           (lp_acc),
    .diff          (lp_diff),
    .ctl           (lp_ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_a)   a_valid  <= s_tvalid;
      if (en_b)   b_valid  <= a_valid;
      if (en_c)   c_valid  <= b_valid;
      if (en_out) m_tvalid <= c_valid;
    end
  end

  // Exact sum of the products, floor shift, saturation.
  logic signed [PW+2:0] total;
  logic signed [PW+2:0] shifted;
  logic                 fits;

  always_comb begin
    total   = c_p + c_i + c_d;
    shifted = total >>> FRAC_BITS;
    fits    = (&shifted[PW+2:DATA_WIDTH-1]) || !(|shifted[PW+2:DATA_WIDTH-1]);
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_meas <= s_tdata[DATA_WIDTH-1:0];
    end
    if (en_b) begin
      b_err  <= lp_err;
      b_acc  <= lp_acc;
      b_diff <= lp_diff;
      b_ctl  <= lp_ctl;
    end
    if (en_c) begin
      c_p    <= kp * b_err;
      c_i    <= ki * b_acc;
      if (b_ctl.use_d) begin
        c_d <= kd * b_diff;
      end else begin
        c_d <= '0;
      end
      c_clip <= b_ctl.clip;
    end
    if (en_out) begin
      if (fits) begin
        drive <= shifted[DATA_WIDTH-1:0];
      end else begin
        drive <= shifted[PW+2] ? MINV : MAXV;
      end
      clipped <= c_clip || !fits;
    end
  end

  assign m_tdata = TDATA_W'(drive);
  assign m_tuser = clipped;

endmodule

### design/pidc_checker.sv
module pidc_checker #(
  parameter  int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [TDATA_W-1:0]   s_tdata,   // measured
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [TDATA_W-1:0]   m_tdata,   // drive
  input logic                 m_tuser,   // clipped
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input pidc_pkg::cfg_index_t cfg_index,
  input logic [DATA_WIDTH-1:0] cfg_data
);

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // When the output can drain, every stage can advance, so input is taken.
  a_ready_flow: assert property (@(posedge clk)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled although the output can drain");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind pid_controller_clamped_integral pidc_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_pidc_checker (.*);
